FILE: sv/sbda_pkg.sv
`default_nettype none

package sbda_pkg;

  localparam int VALUE_BITS = 32;
  // decimal digits of the largest unsigned value of VALUE_BITS bits
  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int IDX_W = $clog2(NDIG);
  localparam int CNT_W = $clog2(VALUE_BITS);

  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic lead_zero;
    logic neg;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/sbda_datapath.sv
`default_nettype none

module sbda_datapath (
  input  wire logic                                clk,
  input  wire logic [sbda_pkg::VALUE_BITS-1:0]     value,
  input  wire sbda_pkg::dp_cmd_t                   cmd,
  output sbda_pkg::dp_status_t                     status,
  output logic [7:0]                               character,
  output logic                                     last
);

  logic [sbda_pkg::VALUE_BITS-1:0]   mag;
  logic                              neg;
  logic [sbda_pkg::NDIG-1:0][3:0]    bcd;
  logic [sbda_pkg::NDIG-1:0][3:0]    bcd_adj;
  logic [sbda_pkg::NDIG*4-1:0]       bcd_flat;
  logic [sbda_pkg::CNT_W-1:0]        cnt;
  logic [sbda_pkg::IDX_W-1:0]        idx;
  logic [3:0]                        cur_digit;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < sbda_pkg::NDIG; d++) begin
      bcd_adj[d] = (bcd[d] >= 4'd5) ? bcd[d] + 4'd3 : bcd[d];
    end
  end

  assign bcd_flat = bcd_adj;

  assign cur_digit = bcd[idx];

  assign status.conv_done = (cnt == sbda_pkg::CNT_W'(sbda_pkg::VALUE_BITS - 1));
  assign status.lead_zero = (idx != '0) && (cur_digit == 4'd0);
  assign status.neg = neg;
  assign status.last = last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[sbda_pkg::VALUE_BITS-1];
      // negation of the most negative value still fits as unsigned
      mag <= value[sbda_pkg::VALUE_BITS-1] ? (~value + 1'b1) : value;
      bcd <= '0;
      cnt <= '0;
      idx <= sbda_pkg::IDX_W'(sbda_pkg::NDIG - 1);
    end
    if (cmd.shift) begin
      bcd <= {bcd_flat[sbda_pkg::NDIG*4-2:0], mag[sbda_pkg::VALUE_BITS-1]};
      mag <= {mag[sbda_pkg::VALUE_BITS-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
    if (cmd.skip) begin
      idx <= idx - 1'b1;
    end
    if (cmd.emit_sign) begin
      character <= sbda_pkg::CHAR_MINUS;
      last <= 1'b0;
    end
    if (cmd.emit_digit) begin
      character <= sbda_pkg::CHAR_ZERO + {4'b0000, cur_digit};
      last <= (idx == '0);
      if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/sbda_ctrl.sv
`default_nettype none

module sbda_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire sbda_pkg::dp_status_t  status,
  output sbda_pkg::dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CONV,
    SKIP,
    SIGN,
    DIGIT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: cmd.load = in_valid;
      CONV: cmd.shift = 1'b1;
      SKIP: begin
        if (status.lead_zero) begin
          cmd.skip = 1'b1;
        end else if (status.neg) begin
          cmd.emit_sign = 1'b1;
        end else begin
          cmd.emit_digit = 1'b1;
        end
      end
      SIGN: cmd.emit_digit = out_ready;
      DIGIT: cmd.emit_digit = out_ready && !status.last;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      in_ready <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= CONV;
            in_ready <= 1'b0;
          end
        end
        CONV: begin
          if (status.conv_done) begin
            state <= SKIP;
          end
        end
        SKIP: begin
          if (!status.lead_zero) begin
            out_valid <= 1'b1;
            state <= status.neg ? SIGN : DIGIT;
          end
        end
        SIGN: begin
          if (out_ready) begin
            state <= DIGIT;
          end
        end
        DIGIT: begin
          if (out_ready && status.last) begin
            state <= IDLE;
            out_valid <= 1'b0;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
          in_ready <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/signed_binary_to_decimal_ascii.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------
// input    | in_valid / in_ready  | value (32 bits, signed)
// output   | out_valid / out_ready| character (8 bits), last (1 bit)
//
// one request at a time: accept, a shift-add-3 step for each of the 32 value
// bits, skip up to 9 leading zero digits, then one character per cycle
// while out_ready is high.
// rst is synchronous and clears the controller only.
// a stalled output holds its character; no new request is taken until the
// last character of the current one is delivered.
`default_nettype none

module signed_binary_to_decimal_ascii (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sbda_pkg::VALUE_BITS-1:0]  value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [7:0]                            character,
  output logic                                  last
);

  sbda_pkg::dp_cmd_t    cmd;
  sbda_pkg::dp_status_t status;

  sbda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sbda_datapath u_datapath (
    .clk       (clk),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last      (last)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a character is pending");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character == sbda_pkg::CHAR_MINUS) |-> !last)
    else $error("minus sign flagged as last character");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (!out_valid && in_ready))
    else $error("output still valid after last character");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef logic [sbda_pkg::VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } text_char_t;

  localparam int N_RANDOM = 359;
  localparam int IDLE_PCT = 13;
  // idle-free stretch, in clock cycles
  localparam int QUIET_FROM = 6000;
  localparam int QUIET_TO = 10000;
  localparam int DRAIN_CYCLES = 80;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  value_t value = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic [7:0] character;
  logic   last;

  value_t     pending_values[$];
  text_char_t expected_text[$];
  int         n_total = 0;
  int         n_accepted = 0;
  int         n_errors = 0;
  int         cyc = 0;
  logic       quiet;

  signed_binary_to_decimal_ascii u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  always #6 clk = ~clk;

  assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // decimal text of one signed value, appended to the expected characters
  task automatic push_decimal_text(input value_t v);
    logic [63:0] mag;
    value_t      mag_short;
    logic [3:0]  digits[$];
    logic [3:0]  d;
    logic        neg;
    neg = v[sbda_pkg::VALUE_BITS-1];
    // the most negative value negates to itself, read unsigned it is right
    mag_short = neg ? (~v + 1'b1) : v;
    mag = '0;
    mag[sbda_pkg::VALUE_BITS-1:0] = mag_short;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      expected_text.push_back('{ch: sbda_pkg::CHAR_MINUS, lst: 1'b0});
    end
    while (digits.size() > 0) begin
      d = digits.pop_front();
      expected_text.push_back('{ch: sbda_pkg::CHAR_ZERO + 8'(d),
                                lst: digits.size() == 0});
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        push_decimal_text(value);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_values.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    text_char_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d last %0b", character, last));
        end else begin
          e = expected_text.pop_front();
          if (character !== e.ch) begin
            report_mismatch($sformatf("character %0d, expected %0d", character, e.ch));
          end
          if (last !== e.lst) begin
            report_mismatch($sformatf("last %0b, expected %0b", last, e.lst));
          end
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic queue_value(input value_t v);
    pending_values.push_back(v);
    n_total++;
  endtask

  initial begin : stimulus
    value_t v;
    int     shift;
    // extremes, zero, digit-count boundaries and sign handling
    queue_value('0);
    queue_value(value_t'(1));
    queue_value('1);
    queue_value(value_t'(9));
    queue_value(value_t'(10));
    queue_value(value_t'(-10));
    queue_value(value_t'(99));
    queue_value(value_t'(100));
    queue_value(value_t'(-9));
    queue_value({1'b0, {(sbda_pkg::VALUE_BITS-1){1'b1}}});
    queue_value({1'b1, {(sbda_pkg::VALUE_BITS-1){1'b0}}});
    queue_value({1'b1, {(sbda_pkg::VALUE_BITS-2){1'b0}}, 1'b1});
    queue_value(value_t'(1000000000));
    queue_value(value_t'(999999999));
    queue_value(value_t'(-999999999));
    queue_value(value_t'(-1000000000));
    queue_value(value_t'(1000000));
    queue_value(value_t'(32'h5555_5555));
    queue_value(value_t'(32'hAAAA_AAAA));
    queue_value(value_t'(7));
    queue_value(value_t'(-7));
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(2) == 0) begin
        v = value_t'($urandom);
      end else begin
        // spread over all text lengths
        shift = $urandom_range(sbda_pkg::VALUE_BITS - 1);
        v = value_t'($urandom) >> shift;
        if ($urandom_range(1) == 1) begin
          v = ~v + 1'b1;
        end
      end
      queue_value(v);
    end
  end

  initial begin : run_control
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    do begin
      @(negedge clk);
    end while (n_accepted < n_total || expected_text.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
